### rtl/core/bipc_pkg.sv
package bipc_pkg;

    // Fixed widths of the design.
    localparam int TIME_BITS    = 32;
    localparam int BUTTON_COUNT = 4;
    localparam int BTN_W        = 2;
    localparam int CMD_W        = 2;
    localparam int MODE_W       = 2;
    localparam int DUTY_W       = 11;
    localparam int SECS_W       = 13;
    localparam int DEBOUNCE_W   = 20;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 20;

    // Seconds times one million needs the sum of both operand widths.
    localparam int US_PER_S   = 1000000;
    localparam int US_W       = 20;
    localparam int SCALE_W    = SECS_W + US_W;
    localparam int DARK_LIMIT = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd2;

    // Mode codes reported with every result.
    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_BRIGHTNESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_BRIGHTNESS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_BRIGHTNESS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_TIMEOUT_S     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_TIMEOUT_S   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_US       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0]     NORMAL_RESET   = 11'd1024;
    localparam logic [DUTY_W-1:0]     DIM_RESET      = 11'd32;
    localparam logic [DUTY_W-1:0]     SLEEP_RESET    = 11'd0;
    localparam logic [TIME_BITS-1:0]  DIM_TMO_RESET  = TIME_BITS'(15 * US_PER_S);
    localparam logic [TIME_BITS-1:0]  SLEEP_TMO_RESET = TIME_BITS'(60 * US_PER_S);
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd200000;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [TIME_BITS-1:0] now_us;
        logic [BTN_W-1:0]     button;
        logic                 inhibit;
    } event_word_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pwm_write;
        logic [DUTY_W-1:0] pwm_duty;
        logic              redraw;
        logic              sleep_warning;
        logic              bounce_dropped;
        logic              key_valid;
        logic [BTN_W-1:0]  key_code;
    } result_word_t;

    // Timeouts are kept already scaled to microseconds.
    typedef struct packed {
        logic [DUTY_W-1:0]     normal_brightness;
        logic [DUTY_W-1:0]     dim_brightness;
        logic [DUTY_W-1:0]     sleep_brightness;
        logic [TIME_BITS-1:0]  dim_timeout_us;
        logic [TIME_BITS-1:0]  sleep_timeout_us;
        logic [DEBOUNCE_W-1:0] debounce_us;
    } cfg_t;

    typedef struct packed {
        logic                                 dim_flag;
        logic                                 asleep_flag;
        logic [TIME_BITS-1:0]                 activity_stamp;
        logic [TIME_BITS-1:0]                 dim_stamp;
        logic [BUTTON_COUNT-1:0][TIME_BITS-1:0] press_stamps;
    } state_t;

endpackage

### rtl/core/bipc_event_if.sv
interface bipc_event_if import bipc_pkg::*; ();
    logic        valid;
    logic        ready;
    event_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bipc_result_if.sv
interface bipc_result_if import bipc_pkg::*; ();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bipc_cfg.sv
module bipc_cfg import bipc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [SCALE_W-1:0] scaled;
    logic [TIME_BITS-1:0] scaled_sat;

    // Seconds are scaled once at write time, saturating at the time range.
    assign scaled     = SCALE_W'(cfg_data[SECS_W-1:0]) * SCALE_W'(US_PER_S);
    assign scaled_sat = (|scaled[SCALE_W-1:TIME_BITS]) ? '1 : scaled[TIME_BITS-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NORMAL_BRIGHTNESS: cfg_next.normal_brightness = cfg_data[DUTY_W-1:0];
                REG_DIM_BRIGHTNESS:    cfg_next.dim_brightness    = cfg_data[DUTY_W-1:0];
                REG_SLEEP_BRIGHTNESS:  cfg_next.sleep_brightness  = cfg_data[DUTY_W-1:0];
                REG_DIM_TIMEOUT_S:     cfg_next.dim_timeout_us    = scaled_sat;
                REG_SLEEP_TIMEOUT_S:   cfg_next.sleep_timeout_us  = scaled_sat;
                REG_DEBOUNCE_US:       cfg_next.debounce_us       = cfg_data[DEBOUNCE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_brightness <= NORMAL_RESET;
            cfg_reg.dim_brightness    <= DIM_RESET;
            cfg_reg.sleep_brightness  <= SLEEP_RESET;
            cfg_reg.dim_timeout_us    <= DIM_TMO_RESET;
            cfg_reg.sleep_timeout_us  <= SLEEP_TMO_RESET;
            cfg_reg.debounce_us       <= DEBOUNCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/bipc_step.sv
module bipc_step import bipc_pkg::*;
(
    input  event_word_t  word,
    input  cfg_t         cfg,
    input  state_t       state,
    output state_t       state_next,
    output result_word_t result
);

    logic [TIME_BITS-1:0] idle_time;
    logic [TIME_BITS-1:0] low_time;
    logic [TIME_BITS-1:0] press_gap;
    logic                 timeouts_off;
    logic                 btn_in_range;
    logic                 sleep_dark;

    assign idle_time    = word.now_us - state.activity_stamp;
    assign low_time     = word.now_us - state.dim_stamp;
    assign btn_in_range = int'(word.button) < BUTTON_COUNT;
    assign press_gap    = word.now_us - state.press_stamps[word.button];
    assign timeouts_off = (cfg.dim_timeout_us == '0) && (cfg.sleep_timeout_us == '0);
    assign sleep_dark   = int'(cfg.sleep_brightness) < DARK_LIMIT;

    always_comb
    begin
        state_next = state;
        result     = '0;

        unique case (word.command)
            CMD_TICK:
            begin
                priority if (timeouts_off)
                begin
                    // With both timeouts off a tick wakes a dimmed or sleeping display.
                    if (state.dim_flag || state.asleep_flag)
                    begin
                        state_next.activity_stamp = word.now_us;
                        state_next.dim_flag       = 1'b0;
                        state_next.asleep_flag    = 1'b0;
                        result.pwm_write          = 1'b1;
                        result.pwm_duty           = cfg.normal_brightness;
                        result.redraw             = 1'b1;
                    end
                end
                else if (!state.dim_flag && !state.asleep_flag)
                begin
                    if (cfg.dim_timeout_us != '0 && idle_time > cfg.dim_timeout_us
                        && !word.inhibit)
                    begin
                        state_next.dim_flag  = 1'b1;
                        state_next.dim_stamp = word.now_us;
                        result.pwm_write     = 1'b1;
                        result.pwm_duty      = cfg.dim_brightness;
                    end
                end
                else if (state.dim_flag && !state.asleep_flag)
                begin
                    if (cfg.sleep_timeout_us != '0 && low_time > cfg.sleep_timeout_us
                        && !word.inhibit)
                    begin
                        state_next.asleep_flag = 1'b1;
                        result.pwm_write       = 1'b1;
                        result.pwm_duty        = cfg.sleep_brightness;
                        result.redraw          = sleep_dark;
                        result.sleep_warning   = sleep_dark;
                    end
                end
                else
                begin
                    // A sleeping display stays asleep until something wakes it.
                end
            end

            CMD_PRESS:
            begin
                if (btn_in_range)
                begin
                    if (press_gap < TIME_BITS'(cfg.debounce_us))
                    begin
                        result.bounce_dropped = 1'b1;
                    end
                    else
                    begin
                        state_next.press_stamps[word.button] = word.now_us;
                        state_next.activity_stamp            = word.now_us;
                        state_next.dim_flag                  = 1'b0;
                        state_next.asleep_flag               = 1'b0;
                        if (state.dim_flag || state.asleep_flag)
                        begin
                            result.pwm_write = 1'b1;
                            result.pwm_duty  = cfg.normal_brightness;
                            result.redraw    = 1'b1;
                        end
                        // A press that wakes a sleeping display is swallowed.
                        result.key_valid = !state.asleep_flag;
                        result.key_code  = state.asleep_flag ? '0 : word.button;
                    end
                end
            end

            CMD_SLEEP:
            begin
                if (!word.inhibit)
                begin
                    priority if (!state.dim_flag)
                    begin
                        state_next.dim_flag  = 1'b1;
                        state_next.dim_stamp = word.now_us;
                        result.pwm_write     = 1'b1;
                        result.pwm_duty      = cfg.dim_brightness;
                    end
                    else if (!state.asleep_flag)
                    begin
                        state_next.asleep_flag = 1'b1;
                        result.pwm_write       = 1'b1;
                        result.pwm_duty        = cfg.sleep_brightness;
                        result.redraw          = sleep_dark;
                        result.sleep_warning   = sleep_dark;
                    end
                    else
                    begin
                        // Nothing is deeper than sleep.
                    end
                end
            end

            default:
            begin
                state_next = state;
            end
        endcase

        result.mode = state_next.asleep_flag ? MODE_SLEEP :
                      (state_next.dim_flag ? MODE_LOW : MODE_ACTIVE);
    end

endmodule

### rtl/core/backlight_idle_power_controller_core.sv
// Channel   Direction  Word            Handshake
// events    in         event_word_t    valid/ready, taken when both are high
// results   out        result_word_t   valid/ready, taken when both are high
// cfg       in         index + data    cfg_write, taken at every edge it is high
//
// Every event word yields exactly one result word; it passes the input register
// and then the result register. While results do not stall a new event word is
// taken every cycle; one word per register makes throughput one word per cycle.
// A stalled result holds the result register, and the input register then
// holds its word until the result moves on.
// rst_n clears the mode flags, the time stamps and all per-button press stamps
// and loads the configuration registers with their default values.
module backlight_idle_power_controller_core import bipc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    bipc_event_if.sink             events,
    bipc_result_if.source          results,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg;
    state_t       state_reg;
    state_t       state_next;
    result_word_t step_result;

    logic         in_valid_reg;
    event_word_t  in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;
    logic         advance;

    // Timeouts are scaled to microseconds when they are written.
    bipc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The whole mode update for one word is a short combinational step:
    // three wrapping subtracts with compares and some selection.
    bipc_step u_step
    (
        .word       (in_word_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // The state is updated exactly when the registered word moves into the
    // result register, so words are applied in order and only once.
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign events.ready  = !in_valid_reg || advance;
    assign results.valid = out_valid_reg;
    assign results.data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (events.valid && events.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            in_word_reg <= events.data;
        end
        if (advance)
        begin
            out_word_reg <= step_result;
        end
    end

endmodule
